[src/tssb_pkg.sv]
package tssb_pkg;

	// fixed field widths
	localparam int STAMP_W     = 63;
	localparam int PAY_W       = 32;
	localparam int WIN_W       = 40;
	localparam int FILL_W      = 7;
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 200;

	localparam logic [WIN_W-1:0] WIN_RESET = 40'd5000000000;

	// operation codes
	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_EXACT   = 2'd1;
	localparam logic [1:0] OP_BRACKET = 2'd2;

	// result status codes
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STS_EMPTY     = 2'd2;
	localparam logic [1:0] STS_DROPPED   = 2'd3;

	// bracketing kinds
	localparam logic [1:0] KIND_BETWEEN = 2'd0;
	localparam logic [1:0] KIND_EXACT   = 2'd1;
	localparam logic [1:0] KIND_BEFORE  = 2'd2;
	localparam logic [1:0] KIND_AFTER   = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DROP,
		S_CMP,
		S_INS,
		S_EXP,
		S_LOOK,
		S_RESP
	} tssb_state_t;

	// commands broadcast to every cell
	typedef struct packed {
		logic cmp;
		logic ins;
		logic shl;
	} tssb_cmd_t;

	// search flags from the chain
	typedef struct packed {
		logic exact;
		logic below_head;
		logic after;
	} tssb_flags_t;

endpackage

[src/tssb_cell.sv]
module tssb_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7,
	parameter int PW  = 32
) (
	input  logic                      clk,
	input  tssb_pkg::tssb_cmd_t       cmd,
	input  logic [CW-1:0]             count,
	input  logic [tssb_pkg::STAMP_W-1:0] s,
	input  logic [PW-1:0]             p,
	input  logic [tssb_pkg::STAMP_W-1:0] left_stamp,
	input  logic [PW-1:0]             left_payload,
	input  logic                      left_lt,
	input  logic [tssb_pkg::STAMP_W-1:0] right_stamp,
	input  logic [PW-1:0]             right_payload,
	input  logic                      right_lt,
	output logic [tssb_pkg::STAMP_W-1:0] stamp,
	output logic [PW-1:0]             payload,
	output logic                      lt,
	output logic                      first_ge,
	output logic                      last_lt,
	output logic                      eq
);
	import tssb_pkg::*;

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic [STAMP_W-1:0] stamp_q;
	logic [PW-1:0]      payload_q;
	logic               lt_q;
	logic               eq_q;
	logic               occupied;

	assign occupied = IDX_C < count;

	// compare against the broadcast stamp, then shift or insert
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			lt_q <= occupied && (stamp_q < s);
			eq_q <= occupied && (stamp_q == s);
		end
		if (cmd.shl) begin
			stamp_q   <= right_stamp;
			payload_q <= right_payload;
		end else if (cmd.ins && !lt_q) begin
			if (left_lt) begin
				stamp_q   <= s;
				payload_q <= p;
			end else begin
				stamp_q   <= left_stamp;
				payload_q <= left_payload;
			end
		end
	end

	assign stamp    = stamp_q;
	assign payload  = payload_q;
	assign lt       = lt_q;
	assign eq       = eq_q;
	assign first_ge = occupied && !lt_q && left_lt;
	assign last_lt  = lt_q && !right_lt;

endmodule

[src/tssb_chain.sv]
module tssb_chain #(
	parameter int DEPTH = 64,
	parameter int CW    = 7,
	parameter int PW    = 32
) (
	input  logic                         clk,
	input  tssb_pkg::tssb_cmd_t          cmd,
	input  logic [CW-1:0]                count,
	input  logic [tssb_pkg::STAMP_W-1:0] s,
	input  logic [PW-1:0]                p,
	output tssb_pkg::tssb_flags_t        flags,
	output logic [tssb_pkg::STAMP_W-1:0] head_stamp,
	output logic [tssb_pkg::STAMP_W-1:0] ge_stamp,
	output logic [PW-1:0]                ge_payload,
	output logic [tssb_pkg::STAMP_W-1:0] lt_stamp,
	output logic [PW-1:0]                lt_payload
);
	import tssb_pkg::*;

	logic [STAMP_W-1:0] stamp_w   [DEPTH];
	logic [PW-1:0]      payload_w [DEPTH];
	logic [DEPTH-1:0]   lt_w;
	logic [DEPTH-1:0]   fg_w;
	logic [DEPTH-1:0]   ll_w;
	logic [DEPTH-1:0]   eq_w;

	// row of cells, each linked to both neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [STAMP_W-1:0] l_stamp;
		logic [PW-1:0]      l_pay;
		logic               l_lt;
		logic [STAMP_W-1:0] r_stamp;
		logic [PW-1:0]      r_pay;
		logic               r_lt;

		if (i == 0) begin : g_first
			assign l_stamp = '0;
			assign l_pay   = '0;
			assign l_lt    = 1'b1;
		end else begin : g_mid_l
			assign l_stamp = stamp_w[i-1];
			assign l_pay   = payload_w[i-1];
			assign l_lt    = lt_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_stamp = stamp_w[i];
			assign r_pay   = payload_w[i];
			assign r_lt    = 1'b0;
		end else begin : g_mid_r
			assign r_stamp = stamp_w[i+1];
			assign r_pay   = payload_w[i+1];
			assign r_lt    = lt_w[i+1];
		end

		tssb_cell #(
			.IDX (i),
			.CW  (CW),
			.PW  (PW)
		) u_cell (
			.clk           (clk),
			.cmd           (cmd),
			.count         (count),
			.s             (s),
			.p             (p),
			.left_stamp    (l_stamp),
			.left_payload  (l_pay),
			.left_lt       (l_lt),
			.right_stamp   (r_stamp),
			.right_payload (r_pay),
			.right_lt      (r_lt),
			.stamp         (stamp_w[i]),
			.payload       (payload_w[i]),
			.lt            (lt_w[i]),
			.first_ge      (fg_w[i]),
			.last_lt       (ll_w[i]),
			.eq            (eq_w[i])
		);
	end

	// one-hot pick of the first sample not older and the last sample older
	always_comb begin
		ge_stamp   = '0;
		ge_payload = '0;
		lt_stamp   = '0;
		lt_payload = '0;
		for (int i = 0; i < DEPTH; i++) begin
			ge_stamp   = ge_stamp   | (stamp_w[i]   & {STAMP_W{fg_w[i]}});
			ge_payload = ge_payload | (payload_w[i] & {PW{fg_w[i]}});
			lt_stamp   = lt_stamp   | (stamp_w[i]   & {STAMP_W{ll_w[i]}});
			lt_payload = lt_payload | (payload_w[i] & {PW{ll_w[i]}});
		end
	end

	assign flags.exact      = |(fg_w & eq_w);
	assign flags.below_head = !lt_w[0];
	assign flags.after      = !(|fg_w);
	assign head_stamp       = stamp_w[0];

endmodule

[src/timestamp_sorted_sample_buffer_top.sv]
// Time-sorted sample buffer: holds up to DEPTH samples (63-bit nanosecond
// stamp plus payload) oldest first in a row of shift cells. Opcode in
// s_tuser picks insert, exact lookup or bracketing lookup; every word
// accepted gives exactly one result word. A lookup steps through accept,
// compare in all cells, select and result. A lookup on an empty store or
// an unused opcode goes from accept straight to result. An insert steps
// through accept, compare, insert and result, with a drop step ahead of
// the compare when the store is full and the oldest sample is dropped; an
// append of a sample newer than all stored ones adds an expiry check that
// shifts out each sample evicted by the expiry window, since the cell row
// moves one position per cycle. One operation is in flight at a time; a
// result waiting on m_tready does not hold up acceptance of the next word,
// only the result of that next word waits for it. Entries start undefined
// and need no clearing after reset. The user must write the expiry window
// on the cfg port only while the block is idle; the block itself does not enforce it.
module timestamp_sorted_sample_buffer_top #(
	parameter int DEPTH        = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration: expiry window in ns
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tssb_pkg::WIN_W-1:0]       cfg_data,
	// input words
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// stamp[62:0], payload[94:63], zero pad
	input  logic [tssb_pkg::IN_TDATA_W-1:0]  s_tdata,
	// opcode[1:0]
	input  logic [1:0]                       s_tuser,
	// result words
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// lower_stamp[62:0], lower_payload[94:63], upper_stamp[157:95],
	// upper_payload[189:158], fill_count[196:190], zero pad
	output logic [tssb_pkg::OUT_TDATA_W-1:0] m_tdata,
	// status[1:0], bound_kind[3:2]
	output logic [3:0]                       m_tuser
);
	import tssb_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	tssb_state_t state_q, state_nx;
	tssb_cmd_t   cmd;
	tssb_flags_t flags;

	logic [CW-1:0]      count_q;
	logic [WIN_W-1:0]   window_q;
	logic [1:0]         op_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [PW-1:0]      pay_q;
	logic [STAMP_W-1:0] limit_q;
	logic [1:0]         res_status_q;
	logic [1:0]         res_kind_q;
	logic [STAMP_W-1:0] res_lo_stamp_q;
	logic [PAY_W-1:0]   res_lo_pay_q;
	logic [STAMP_W-1:0] res_up_stamp_q;
	logic [PAY_W-1:0]   res_up_pay_q;
	logic               out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [3:0]         out_user_q;

	logic [STAMP_W-1:0] head_stamp;
	logic [STAMP_W-1:0] ge_stamp;
	logic [PW-1:0]      ge_payload;
	logic [STAMP_W-1:0] lt_stamp;
	logic [PW-1:0]      lt_payload;

	logic               in_fire;
	logic               out_free;
	logic               full;
	logic               expire_hit;
	logic [1:0]         in_op;
	logic [STAMP_W-1:0] in_stamp;
	logic [PAY_W-1:0]   in_pay;
	logic [STAMP_W-1:0] win_ext;
	logic [STAMP_W-1:0] in_limit;

	assign in_op    = s_tuser;
	assign in_stamp = s_tdata[STAMP_W-1:0];
	assign in_pay   = s_tdata[STAMP_W+PAY_W-1:STAMP_W];
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign full     = count_q == DEPTH_C;
	assign expire_hit = (count_q != '0) && (head_stamp < limit_q);

	// oldest stamp still inside the window, floored at zero
	assign win_ext  = STAMP_W'(window_q);
	assign in_limit = (in_stamp > win_ext) ? (in_stamp - win_ext) : '0;

	tssb_chain #(
		.DEPTH (DEPTH),
		.CW    (CW),
		.PW    (PW)
	) u_chain (
		.clk        (clk),
		.cmd        (cmd),
		.count      (count_q),
		.s          (stamp_q),
		.p          (pay_q),
		.flags      (flags),
		.head_stamp (head_stamp),
		.ge_stamp   (ge_stamp),
		.ge_payload (ge_payload),
		.lt_stamp   (lt_stamp),
		.lt_payload (lt_payload)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (in_op == OP_INSERT) begin
						state_nx = full ? S_DROP : S_CMP;
					end else if ((in_op == OP_EXACT || in_op == OP_BRACKET)
						&& count_q != '0) begin
						state_nx = S_CMP;
					end else begin
						state_nx = S_RESP;
					end
				end
			end
			S_DROP: state_nx = S_CMP;
			S_CMP:  state_nx = (op_q == OP_INSERT) ? S_INS : S_LOOK;
			S_INS:  state_nx = flags.after ? S_EXP : S_RESP;
			S_EXP: begin
				if (!expire_hit) begin
					state_nx = S_RESP;
				end
			end
			S_LOOK: state_nx = S_RESP;
			S_RESP: begin
				if (out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// cell commands and handshake outputs
	always_comb begin
		cmd.cmp  = state_q == S_CMP;
		cmd.ins  = state_q == S_INS;
		cmd.shl  = (state_q == S_DROP) || (state_q == S_EXP && expire_hit);
		s_tready = state_q == S_IDLE;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			window_q    <= WIN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid) begin
				window_q <= cfg_data;
			end
			if (state_q == S_INS) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.shl) begin
				count_q <= count_q - CW'(1);
			end
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operation and result registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q           <= in_op;
			stamp_q        <= in_stamp;
			pay_q          <= in_pay[PW-1:0];
			limit_q        <= in_limit;
			res_kind_q     <= KIND_BETWEEN;
			res_up_stamp_q <= '0;
			res_up_pay_q   <= '0;
			if (in_op == OP_INSERT) begin
				res_status_q   <= full ? STS_DROPPED : STS_OK;
				res_lo_stamp_q <= in_stamp;
				res_lo_pay_q   <= PAY_W'(in_pay[PW-1:0]);
			end else begin
				res_lo_stamp_q <= '0;
				res_lo_pay_q   <= '0;
				if (in_op == OP_EXACT || in_op == OP_BRACKET) begin
					res_status_q <= (count_q == '0) ? STS_EMPTY : STS_OK;
				end else begin
					res_status_q <= STS_NOT_FOUND;
				end
			end
		end
		// pick the neighbors from the compare flags
		if (state_q == S_LOOK) begin
			if (flags.exact) begin
				res_kind_q     <= KIND_EXACT;
				res_lo_stamp_q <= ge_stamp;
				res_lo_pay_q   <= PAY_W'(ge_payload);
				res_up_stamp_q <= ge_stamp;
				res_up_pay_q   <= PAY_W'(ge_payload);
			end else if (op_q == OP_EXACT) begin
				res_status_q <= STS_NOT_FOUND;
			end else if (flags.after) begin
				res_kind_q     <= KIND_AFTER;
				res_lo_stamp_q <= lt_stamp;
				res_lo_pay_q   <= PAY_W'(lt_payload);
				res_up_stamp_q <= lt_stamp;
				res_up_pay_q   <= PAY_W'(lt_payload);
			end else if (flags.below_head) begin
				res_kind_q     <= KIND_BEFORE;
				res_lo_stamp_q <= ge_stamp;
				res_lo_pay_q   <= PAY_W'(ge_payload);
				res_up_stamp_q <= ge_stamp;
				res_up_pay_q   <= PAY_W'(ge_payload);
			end else begin
				res_kind_q     <= KIND_BETWEEN;
				res_lo_stamp_q <= lt_stamp;
				res_lo_pay_q   <= PAY_W'(lt_payload);
				res_up_stamp_q <= ge_stamp;
				res_up_pay_q   <= PAY_W'(ge_payload);
			end
		end
		// output word register
		if (state_q == S_RESP && out_free) begin
			out_data_q <= {3'b000, FILL_W'(count_q), res_up_pay_q, res_up_stamp_q,
				res_lo_pay_q, res_lo_stamp_q};
			out_user_q <= {res_kind_q, res_status_q};
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_user_q;

	// fill level never passes the row length
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("fill count above depth");

	// the oldest sample is dropped only from a full row
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DROP |-> full)
		else $error("drop from a row that is not full");

	// expiry never empties the row, the appended sample stays
	a_exp_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXP |-> count_q != '0)
		else $error("expiry on an empty row");

	// a lookup leaves the fill level alone
	a_look_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOOK |=> $stable(count_q))
		else $error("lookup changed the fill count");

endmodule

[tb/sample_buffer_checker.sv]
`timescale 1ns / 100ps

module sample_buffer_checker #(
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [tssb_pkg::WIN_W-1:0]       cfg_data,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	// stamp, payload, zero pad
	input  logic [tssb_pkg::IN_TDATA_W-1:0]  s_tdata,
	// opcode
	input  logic [1:0]                       s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// lower_stamp, lower_payload, upper_stamp, upper_payload, fill_count, zero pad
	input  logic [tssb_pkg::OUT_TDATA_W-1:0] m_tdata,
	// status, bound_kind
	input  logic [3:0]                       m_tuser,
	output int                               errors,
	output int                               outstanding
);
	import tssb_pkg::*;

	typedef struct packed {
		logic [1:0]         status;
		logic [1:0]         kind;
		logic [STAMP_W-1:0] lo_stamp;
		logic [PAY_W-1:0]   lo_pay;
		logic [STAMP_W-1:0] hi_stamp;
		logic [PAY_W-1:0]   hi_pay;
		logic [FILL_W-1:0]  fill;
	} buffer_result_t;

	// shadow copy of the sorted store, oldest first
	logic [STAMP_W-1:0] held_stamp [DEPTH];
	logic [PAY_W-1:0]   held_pay [DEPTH];
	int                 held_count;
	logic [WIN_W-1:0]   window_ns;

	buffer_result_t     awaited_results [$];
	int                 fail_count = 0;
	int                 open_count = 0;

	assign errors      = fail_count;
	assign outstanding = open_count;

	// first position whose stamp is not below s
	function automatic int first_not_below(logic [STAMP_W-1:0] s);
		int pos;
		pos = 0;
		while (pos < held_count && held_stamp[pos] < s)
			pos++;
		return pos;
	endfunction

	function automatic void drop_oldest(int n);
		for (int i = 0; i < held_count - n; i++) begin
			held_stamp[i] = held_stamp[i + n];
			held_pay[i]   = held_pay[i + n];
		end
		held_count -= n;
	endfunction

	function automatic void place_sample(int pos, logic [STAMP_W-1:0] s, logic [PAY_W-1:0] p);
		for (int i = held_count; i > pos; i--) begin
			held_stamp[i] = held_stamp[i - 1];
			held_pay[i]   = held_pay[i - 1];
		end
		held_stamp[pos] = s;
		held_pay[pos]   = p;
		held_count++;
	endfunction

	// evict samples older than newest minus window, limit floored at zero
	function automatic void expire_samples();
		logic [STAMP_W-1:0] newest;
		logic [STAMP_W-1:0] limit;
		int                 n;
		newest = held_stamp[held_count - 1];
		limit  = (newest > STAMP_W'(window_ns)) ? newest - STAMP_W'(window_ns) : '0;
		n = 0;
		while (n < held_count && held_stamp[n] < limit)
			n++;
		drop_oldest(n);
	endfunction

	// apply one operation to the shadow store and return its result word
	function automatic buffer_result_t apply_operation(logic [1:0] op, logic [STAMP_W-1:0] s,
			logic [PAY_W-1:0] p);
		buffer_result_t res;
		logic           dropped;
		logic           found;
		int             pos;
		int             lo_i;
		int             hi_i;
		res   = '0;
		lo_i  = 0;
		hi_i  = 0;
		found = 1'b1;
		case (op)
			OP_INSERT: begin
				dropped = (held_count >= DEPTH);
				if (dropped)
					drop_oldest(1);
				if (held_count == 0) begin
					place_sample(0, s, p);
				end else if (s > held_stamp[held_count - 1]) begin
					place_sample(held_count, s, p);
					expire_samples();
				end else begin
					place_sample(first_not_below(s), s, p);
				end
				res.status   = dropped ? STS_DROPPED : STS_OK;
				res.lo_stamp = s;
				res.lo_pay   = p;
			end
			OP_EXACT, OP_BRACKET: begin
				if (held_count == 0) begin
					res.status = STS_EMPTY;
				end else begin
					pos = first_not_below(s);
					if (pos < held_count && held_stamp[pos] == s) begin
						res.kind = KIND_EXACT;
						lo_i = pos;
						hi_i = pos;
					end else if (op == OP_EXACT) begin
						found = 1'b0;
						res.status = STS_NOT_FOUND;
					end else if (pos >= held_count) begin
						res.kind = KIND_AFTER;
						lo_i = held_count - 1;
						hi_i = held_count - 1;
					end else if (pos == 0) begin
						res.kind = KIND_BEFORE;
					end else begin
						res.kind = KIND_BETWEEN;
						lo_i = pos - 1;
						hi_i = pos;
					end
					if (found) begin
						res.lo_stamp = held_stamp[lo_i];
						res.lo_pay   = held_pay[lo_i];
						res.hi_stamp = held_stamp[hi_i];
						res.hi_pay   = held_pay[hi_i];
					end
				end
			end
			default: begin
				res.status = STS_NOT_FOUND;
			end
		endcase
		res.fill = FILL_W'(held_count);
		return res;
	endfunction

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		buffer_result_t want;
		if (!arst_n) begin
			held_count = 0;
			window_ns  = WIN_RESET;
			awaited_results.delete();
			open_count = 0;
		end else begin
			// result word against the oldest expectation
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t ns: result word with none expected, actual %0h / %0h",
						$time, m_tuser, m_tdata);
					fail_count++;
				end else begin
					want = awaited_results[0];
					awaited_results.delete(0);
					compare_field("status", 64'(want.status), 64'(m_tuser[1:0]));
					compare_field("bound_kind", 64'(want.kind), 64'(m_tuser[3:2]));
					compare_field("lower_stamp", 64'(want.lo_stamp), 64'(m_tdata[62:0]));
					compare_field("lower_payload", 64'(want.lo_pay), 64'(m_tdata[94:63]));
					compare_field("upper_stamp", 64'(want.hi_stamp), 64'(m_tdata[157:95]));
					compare_field("upper_payload", 64'(want.hi_pay),
						64'(m_tdata[189:158]));
					compare_field("fill_count", 64'(want.fill), 64'(m_tdata[196:190]));
					compare_field("pad", '0, 64'(m_tdata[199:197]));
				end
			end
			if (cfg_valid && cfg_ready)
				window_ns = cfg_data;
			if (s_tvalid && s_tready)
				awaited_results = {awaited_results, apply_operation(s_tuser,
					s_tdata[62:0], s_tdata[94:63])};
			open_count = awaited_results.size();
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import tssb_pkg::*;

	localparam logic [1:0]         OP_UNUSED = 2'd3;
	localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
	localparam logic [PAY_W-1:0]   PAY_MAX   = '1;
	localparam int                 PHASE_ITEMS = 160;
	localparam int                 RECENT_KEEP = 32;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [WIN_W-1:0]       cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	// stamp, payload, zero pad
	logic [IN_TDATA_W-1:0]  s_tdata;
	// opcode
	logic [1:0]             s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	// lower_stamp, lower_payload, upper_stamp, upper_payload, fill_count, zero pad
	logic [OUT_TDATA_W-1:0] m_tdata;
	// status, bound_kind
	logic [3:0]             m_tuser;

	int                     errors;
	int                     outstanding;
	bit                     stall_en;
	logic [STAMP_W-1:0]     base_stamp;
	logic [STAMP_W-1:0]     recent_stamps [$];

	timestamp_sorted_sample_buffer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	sample_buffer_checker #(
		.DEPTH(64)
	) sb_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// 20 ns clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("FAIL timestamp_sorted_sample_buffer_top");
		$finish;
	end

	// result side back-pressure in bursts
	initial begin
		m_tready <= 1'b1;
		forever begin
			@(negedge clk);
			if (stall_en && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	function automatic logic [63:0] rand_upto(logic [63:0] hi);
		return {$urandom, $urandom} % (hi + 64'd1);
	endfunction

	function automatic logic [STAMP_W-1:0] rand_stamp();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[STAMP_W-1:0];
	endfunction

	function automatic logic [STAMP_W-1:0] pick_recent();
		if (recent_stamps.size() == 0)
			return base_stamp;
		return recent_stamps[$urandom_range(0, recent_stamps.size() - 1)];
	endfunction

	// one input word, with an optional idle burst ahead of it
	task automatic send_word(logic [1:0] op, logic [STAMP_W-1:0] stamp, logic [PAY_W-1:0] pay);
		if (stall_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, pay, stamp};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (op == OP_INSERT) begin
			recent_stamps = {recent_stamps, stamp};
			if (recent_stamps.size() > RECENT_KEEP)
				recent_stamps.delete(0);
		end
	endtask

	// new expiry window, written only with nothing in flight
	task automatic write_window(logic [WIN_W-1:0] win);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= win;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// appends with small steps so the store fills, plus older inserts, lookups near stored stamps and unused opcodes
	task automatic run_phase(logic [WIN_W-1:0] win, int n_items);
		logic [63:0]        span;
		logic [STAMP_W-1:0] stamp;
		int                 r;
		int                 r2;
		span = (64'(win) >> 8) + 64'd2;
		for (int k = 0; k < n_items; k++) begin
			r  = $urandom_range(0, 99);
			r2 = $urandom_range(0, 99);
			if (r < 55) begin
				if (r2 < 72) begin
					base_stamp = STAMP_W'(64'(base_stamp) + rand_upto(span));
					stamp = base_stamp;
				end else if (r2 < 80) begin
					// jump far enough to expire most of the store
					base_stamp = STAMP_W'(64'(base_stamp) + 64'(win) + rand_upto(span));
					stamp = base_stamp;
				end else if (r2 < 88) begin
					stamp = pick_recent();
				end else begin
					stamp = STAMP_W'(64'(pick_recent()) - rand_upto(span));
				end
				send_word(OP_INSERT, stamp, $urandom);
			end else if (r < 75) begin
				stamp = pick_recent();
				if (r2 < 30)
					stamp = stamp + STAMP_W'($urandom_range(0, 2)) - STAMP_W'(1);
				send_word(OP_EXACT, stamp, $urandom);
			end else if (r < 97) begin
				if (r2 < 10)
					stamp = rand_stamp();
				else
					stamp = STAMP_W'(64'(pick_recent()) + rand_upto(2 * span) - span);
				send_word(OP_BRACKET, stamp, $urandom);
			end else begin
				send_word(OP_UNUSED, rand_stamp(), $urandom);
			end
		end
	endtask

	// stimulus
	initial begin
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_INSERT;
		stall_en   = 1'b1;
		base_stamp = STAMP_W'(64'd11_000_000_000);
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// lookups and unused opcode on an empty store
		send_word(OP_EXACT, '0, '0);
		send_word(OP_BRACKET, STAMP_MAX, PAY_MAX);
		send_word(OP_UNUSED, STAMP_MAX, PAY_MAX);
		// first samples, expiry limit floored at zero, equal stamp goes ahead
		send_word(OP_INSERT, '0, '0);
		send_word(OP_INSERT, 63'd1000, PAY_MAX);
		send_word(OP_INSERT, 63'd1000, 32'h0000_1234);
		send_word(OP_INSERT, 63'd500, 32'd5);
		send_word(OP_EXACT, 63'd1000, '0);
		send_word(OP_EXACT, 63'd700, '0);
		send_word(OP_BRACKET, 63'd500, '0);
		send_word(OP_BRACKET, 63'd600, '0);
		send_word(OP_BRACKET, 63'd2000, '0);
		// append past the window evicts all older samples
		send_word(OP_INSERT, 63'd6_000_000_000, 32'd6);
		send_word(OP_BRACKET, 63'd5, '0);
		send_word(OP_INSERT, 63'd5_999_999_999, 32'd7);
		send_word(OP_INSERT, 63'd11_000_000_000, 32'hA5A5_A5A5);
		send_word(OP_EXACT, 63'd6_000_000_000, '0);
		send_word(OP_BRACKET, 63'd8_000_000_000, '0);
		send_word(OP_BRACKET, STAMP_MAX, '0);
		send_word(OP_EXACT, STAMP_MAX, '0);

		// random phases over several windows, extremes included
		write_window('1);
		run_phase('1, PHASE_ITEMS);
		write_window('0);
		run_phase('0, PHASE_ITEMS);
		write_window(40'd1000);
		run_phase(40'd1000, PHASE_ITEMS);
		begin
			logic [WIN_W-1:0] win;
			win = {8'($urandom_range(0, 255)), 32'($urandom)};
			write_window(win);
			run_phase(win, PHASE_ITEMS);
		end
		// last phase runs without idling on either side
		write_window(WIN_RESET);
		stall_en = 1'b0;
		run_phase(WIN_RESET, PHASE_ITEMS);

		// largest stamp stored last, since nothing can be appended after it
		send_word(OP_INSERT, STAMP_MAX, PAY_MAX);
		send_word(OP_EXACT, STAMP_MAX, '0);
		send_word(OP_BRACKET, STAMP_MAX - 63'd1, '0);
		send_word(OP_BRACKET, '0, '0);
		s_tvalid <= 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("PASS timestamp_sorted_sample_buffer_top");
		else
			$display("FAIL timestamp_sorted_sample_buffer_top");
		$finish;
	end

endmodule

[filelist.f]
src/tssb_pkg.sv
src/tssb_cell.sv
src/tssb_chain.sv
src/timestamp_sorted_sample_buffer_top.sv
tb/sample_buffer_checker.sv
tb/testbench.sv
